>>> rtl/ffba_pkg.sv
package ffba_pkg;

	localparam int MAX_BLOCKS   = 64;
	localparam int HEADER_BYTES = 16;
	localparam int ADDR_BITS    = 16;

	localparam int IDX_BITS = (MAX_BLOCKS > 1) ? $clog2(MAX_BLOCKS) : 1;
	localparam int CNT_BITS = $clog2(MAX_BLOCKS + 1);

	localparam int PADDR_BITS = 3;
	localparam logic [0:0] REG_HEAP_LIMIT = 1'b0;
	localparam logic [ADDR_BITS-1:0] HEAP_LIMIT_RST = {ADDR_BITS{1'b1}};

	typedef enum logic {
		ACT_ALLOC = 1'b0,
		ACT_FREE  = 1'b1
	} action_t;

	typedef enum logic [1:0] {
		STS_OK      = 2'd0,
		STS_NULL    = 2'd1,
		STS_OOM     = 2'd2,
		STS_UNKNOWN = 2'd3
	} status_t;

	typedef struct packed {
		logic [ADDR_BITS-1:0] base;
		logic [ADDR_BITS-1:0] size;
		logic                 free;
	} entry_t;

	typedef struct packed {
		logic load;
		logic scan;
		logic commit;
		logic out_load;
	} ffba_cmd_t;

	typedef struct packed {
		logic trivial;
		logic hit;
		logic scan_done;
		logic out_busy;
	} ffba_sts_t;

endpackage

>>> rtl/ffba_ctrl.sv
module ffba_ctrl import ffba_pkg::*; (
	input  logic      clk,
	input  logic      arst_n,
	input  logic      in_valid,
	output logic      in_ready,
	input  ffba_sts_t sts,
	output ffba_cmd_t cmd
);

	typedef enum logic [3:0] {
		ST_IDLE   = 4'b0001,
		ST_SCAN   = 4'b0010,
		ST_COMMIT = 4'b0100,
		ST_RESP   = 4'b1000
	} state_t;

	state_t state_q, state_d;

	always_comb begin
		state_d  = state_q;
		cmd      = '0;
		in_ready = 1'b0;
		case (state_q)
			ST_IDLE: begin
				in_ready = 1'b1;
				if (in_valid) begin
					cmd.load = 1'b1;
					state_d  = ST_SCAN;
				end
			end
			ST_SCAN: begin
				if (sts.trivial) begin
					state_d = ST_COMMIT;
				end else begin
					cmd.scan = 1'b1;
					if (sts.hit || sts.scan_done)
						state_d = ST_COMMIT;
				end
			end
			ST_COMMIT: begin
				cmd.commit = 1'b1;
				state_d    = ST_RESP;
			end
			ST_RESP: begin
				if (!sts.out_busy) begin
					cmd.out_load = 1'b1;
					state_d      = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			state_q <= ST_IDLE;
		else
			state_q <= state_d;
	end

endmodule

>>> rtl/ffba_dp.sv
module ffba_dp import ffba_pkg::*; (
	input  logic                 clk,
	input  logic                 arst_n,
	input  ffba_cmd_t            cmd,
	output ffba_sts_t            sts,
	input  logic [ADDR_BITS-1:0] heap_limit,
	input  logic                 in_action,
	input  logic [ADDR_BITS-1:0] in_req_size,
	input  logic [ADDR_BITS-1:0] in_block_addr,
	output logic                 out_valid,
	input  logic                 out_ready,
	output logic [ADDR_BITS-1:0] out_result_addr,
	output logic [1:0]           out_status
);

	localparam int WIDE = ADDR_BITS + 2;
	localparam logic [WIDE-1:0] HDR_W      = WIDE'(HEADER_BYTES);
	localparam logic [WIDE-1:0] ADDR_MAX_W = WIDE'({ADDR_BITS{1'b1}});
	localparam logic [CNT_BITS-1:0] MAX_CNT = CNT_BITS'(MAX_BLOCKS);

	entry_t mem [MAX_BLOCKS];

	// current item
	action_t              act_q;
	logic [ADDR_BITS-1:0] size_q;
	logic [ADDR_BITS-1:0] addr_q;

	logic [CNT_BITS-1:0]  count_q;
	logic [ADDR_BITS-1:0] break_q;

	// scan pipeline: address counter, then registered read data
	logic [CNT_BITS-1:0]  rd_idx_q;
	logic                 rd_vld_s1;
	logic [IDX_BITS-1:0]  rd_idx_s1;
	entry_t               ent_s1;

	logic                 hit_q;
	logic [IDX_BITS-1:0]  hit_idx_q;
	entry_t               hit_ent_q;

	logic [ADDR_BITS-1:0] res_addr_q;
	status_t              res_status_q;

	logic                 out_valid_q;
	logic [ADDR_BITS-1:0] out_addr_q;
	status_t              out_status_q;

	logic                 match;
	logic                 hit_now;
	logic                 rd_en;
	logic                 trivial;

	logic [WIDE-1:0]      payload_w;
	logic [WIDE-1:0]      new_break_w;
	logic                 no_room;
	logic                 is_top;

	logic                 mem_we;
	logic [IDX_BITS-1:0]  mem_wa;
	entry_t               mem_wd;

	always_comb begin
		if (act_q == ACT_ALLOC)
			match = ent_s1.free && (ent_s1.size >= size_q);
		else
			match = (ent_s1.base == addr_q);
	end

	assign hit_now = rd_vld_s1 && match;
	assign rd_en   = cmd.scan && !hit_now && (rd_idx_q < count_q);
	assign trivial = (act_q == ACT_ALLOC) ? (size_q == '0) : (addr_q == '0);

	assign sts.trivial   = trivial;
	assign sts.hit       = hit_now;
	assign sts.scan_done = !rd_vld_s1 && (rd_idx_q >= count_q);
	assign sts.out_busy  = out_valid_q && !out_ready;

	assign payload_w   = WIDE'(break_q) + HDR_W;
	assign new_break_w = payload_w + WIDE'(size_q);
	assign no_room     = (count_q >= MAX_CNT) || (new_break_w > WIDE'(heap_limit)) ||
		(new_break_w > ADDR_MAX_W);

	// topmost: last entry, ends at the break, has room for its header below
	assign is_top = ((CNT_BITS'(hit_idx_q) + CNT_BITS'(1)) == count_q) &&
		((WIDE'(hit_ent_q.base) + WIDE'(hit_ent_q.size)) == WIDE'(break_q)) &&
		(WIDE'(hit_ent_q.base) >= HDR_W);

	always_comb begin
		mem_we = 1'b0;
		mem_wa = hit_idx_q;
		mem_wd = hit_ent_q;
		if (cmd.commit && !trivial) begin
			if (act_q == ACT_ALLOC) begin
				if (hit_q) begin
					mem_we      = 1'b1;
					mem_wd.free = 1'b0;
				end else if (!no_room) begin
					mem_we      = 1'b1;
					mem_wa      = count_q[IDX_BITS-1:0];
					mem_wd.base = payload_w[ADDR_BITS-1:0];
					mem_wd.size = size_q;
					mem_wd.free = 1'b0;
				end
			end else if (hit_q && !is_top) begin
				mem_we      = 1'b1;
				mem_wd.free = 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (mem_we)
			mem[mem_wa] <= mem_wd;
		if (rd_en) begin
			ent_s1    <= mem[rd_idx_q[IDX_BITS-1:0]];
			rd_idx_s1 <= rd_idx_q[IDX_BITS-1:0];
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			act_q  <= action_t'(in_action);
			size_q <= in_req_size;
			addr_q <= in_block_addr;
		end
		if (cmd.scan && hit_now) begin
			hit_idx_q <= rd_idx_s1;
			hit_ent_q <= ent_s1;
		end
		if (cmd.commit) begin
			res_addr_q <= '0;
			if (trivial) begin
				res_status_q <= STS_NULL;
			end else if (act_q == ACT_ALLOC) begin
				if (hit_q) begin
					res_addr_q   <= hit_ent_q.base;
					res_status_q <= STS_OK;
				end else if (no_room) begin
					res_status_q <= STS_OOM;
				end else begin
					res_addr_q   <= payload_w[ADDR_BITS-1:0];
					res_status_q <= STS_OK;
				end
			end else begin
				res_status_q <= hit_q ? STS_OK : STS_UNKNOWN;
			end
		end
		if (cmd.out_load) begin
			out_addr_q   <= res_addr_q;
			out_status_q <= res_status_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q     <= '0;
			break_q     <= '0;
			rd_idx_q    <= '0;
			rd_vld_s1   <= 1'b0;
			hit_q       <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			rd_vld_s1 <= rd_en;
			if (cmd.load) begin
				rd_idx_q <= '0;
				hit_q    <= 1'b0;
			end else if (rd_en) begin
				rd_idx_q <= rd_idx_q + CNT_BITS'(1);
			end
			if (cmd.scan && hit_now)
				hit_q <= 1'b1;
			if (cmd.commit && !trivial) begin
				if (act_q == ACT_ALLOC) begin
					if (!hit_q && !no_room) begin
						count_q <= count_q + CNT_BITS'(1);
						break_q <= new_break_w[ADDR_BITS-1:0];
					end
				end else if (hit_q && is_top) begin
					count_q <= count_q - CNT_BITS'(1);
					break_q <= hit_ent_q.base - ADDR_BITS'(HEADER_BYTES);
				end
			end
			if (cmd.out_load)
				out_valid_q <= 1'b1;
			else if (out_ready)
				out_valid_q <= 1'b0;
		end
	end

	assign out_valid       = out_valid_q;
	assign out_result_addr = out_addr_q;
	assign out_status      = out_status_q;

endmodule

>>> rtl/first_fit_block_allocator.sv
// channel   dir  handshake                 payload
// s_axis    in   s_tvalid / s_tready       tdata {block_addr, req_size}, tuser action
// m_axis    out  m_tvalid / m_tready       tdata result_addr, tuser status
// apb       in   psel, penable, pready=1   reg 0 heap_limit at byte address 0
//
// one word at a time: a word is scanned, committed and handed to the output register
// before the next is accepted; the scan reads up to block_count entries, at most
// MAX_BLOCKS, through the one-read-port block table.
// reset empties the table and the break at once; no clearing pass.
// a finished word sits in the output register, so the next word is taken
// while it waits; the scan of that word only stalls at the result hand-off.
module first_fit_block_allocator import ffba_pkg::*; (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  s_tvalid,
	output logic                  s_tready,
	input  logic [31:0]           s_tdata,   // [15:0] req_size, [31:16] block_addr
	input  logic                  s_tuser,   // [0] action
	output logic                  m_tvalid,
	input  logic                  m_tready,
	output logic [15:0]           m_tdata,   // [15:0] result_addr
	output logic [1:0]            m_tuser,   // [1:0] status
	input  logic                  psel,
	input  logic                  penable,
	input  logic                  pwrite,
	input  logic [PADDR_BITS-1:0] paddr,
	input  logic [31:0]           pwdata,
	output logic [31:0]           prdata,
	output logic                  pready
);

	logic [ADDR_BITS-1:0] heap_limit_q;
	logic                 reg_sel;
	ffba_cmd_t            cmd;
	ffba_sts_t            sts;

	assign pready  = 1'b1;
	assign reg_sel = (paddr[PADDR_BITS-1] == REG_HEAP_LIMIT);
	assign prdata  = reg_sel ? 32'(heap_limit_q) : '0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			heap_limit_q <= HEAP_LIMIT_RST;
		else if (psel && penable && pwrite && reg_sel)
			heap_limit_q <= pwdata[ADDR_BITS-1:0];
	end

	ffba_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (s_tvalid),
		.in_ready (s_tready),
		.sts      (sts),
		.cmd      (cmd)
	);

	ffba_dp u_dp (
		.clk             (clk),
		.arst_n          (arst_n),
		.cmd             (cmd),
		.sts             (sts),
		.heap_limit      (heap_limit_q),
		.in_action       (s_tuser),
		.in_req_size     (s_tdata[15:0]),
		.in_block_addr   (s_tdata[31:16]),
		.out_valid       (m_tvalid),
		.out_ready       (m_tready),
		.out_result_addr (m_tdata),
		.out_status      (m_tuser)
	);

endmodule

>>> tb/sv/tb.sv
module tb import ffba_pkg::*; ();
	timeunit 1ns;
	timeprecision 1ps;

	localparam logic [PADDR_BITS-1:0] LIMIT_ADDR = PADDR_BITS'(int'(REG_HEAP_LIMIT) * 4);
	localparam int HOLD_CYCLES = 400;

	typedef struct packed {
		logic [ADDR_BITS-1:0] addr;
		status_t              status;
	} grant_t;

	// shadow of the allocator: block table, break and limit, plus grants still owed
	class heap_shadow;
		logic [ADDR_BITS-1:0] base_tab [MAX_BLOCKS];
		logic [ADDR_BITS-1:0] size_tab [MAX_BLOCKS];
		bit                   free_tab [MAX_BLOCKS];
		int unsigned          count;
		longint unsigned      brk;
		longint unsigned      limit;
		grant_t               grants_due [$];
		int                   errors;
		int                   n_reuse, n_append, n_drop, n_mark, n_full;
		int                   status_seen [4];

		function new();
			count = 0;
			brk = 0;
			limit = HEAP_LIMIT_RST;
			errors = 0;
		endfunction

		function void set_limit(logic [ADDR_BITS-1:0] v);
			limit = v;
		endfunction

		function void note_request(action_t act, logic [15:0] sz, logic [15:0] ad);
			grant_t          g;
			int              hit;
			longint unsigned payload, nb, addr_max;
			hit = -1;
			g = '{addr: '0, status: STS_OK};
			addr_max = (64'd1 << ADDR_BITS) - 1;
			if (act == ACT_ALLOC) begin
				if (sz == 0) begin
					g.status = STS_NULL;
				end else begin
					for (int i = 0; i < count; i++)
						if (hit < 0 && free_tab[i] && size_tab[i] >= sz)
							hit = i;
					if (hit >= 0) begin
						free_tab[hit] = 1'b0;
						g.addr = base_tab[hit];
						n_reuse++;
					end else begin
						payload = brk + HEADER_BYTES;
						nb = payload + sz;
						if (count >= MAX_BLOCKS || nb > limit || nb > addr_max) begin
							g.status = STS_OOM;
							if (count >= MAX_BLOCKS)
								n_full++;
						end else begin
							base_tab[count] = payload[ADDR_BITS-1:0];
							size_tab[count] = sz;
							free_tab[count] = 1'b0;
							count++;
							brk = nb;
							g.addr = payload[ADDR_BITS-1:0];
							n_append++;
						end
					end
				end
			end else begin
				if (ad == 0) begin
					g.status = STS_NULL;
				end else begin
					for (int i = 0; i < count; i++)
						if (hit < 0 && base_tab[i] == ad)
							hit = i;
					if (hit < 0) begin
						g.status = STS_UNKNOWN;
					end else if (hit + 1 == count
						&& longint'(base_tab[hit]) + size_tab[hit] == brk
						&& base_tab[hit] >= HEADER_BYTES) begin
						// topmost block gives its space back to the break
						brk = base_tab[hit] - HEADER_BYTES;
						count--;
						n_drop++;
					end else begin
						free_tab[hit] = 1'b1;
						n_mark++;
					end
				end
			end
			status_seen[int'(g.status)]++;
			grants_due.push_back(g);
		endfunction

		task report(string what);
			$display("%0t mismatch: %s", $time, what);
			errors++;
		endtask

		task check_grant(logic [15:0] got_addr, status_t got_sts);
			grant_t want;
			if (grants_due.size() == 0) begin
				report($sformatf("result addr %h status %0d with nothing pending",
					got_addr, got_sts));
				return;
			end
			want = grants_due.pop_front();
			if (got_addr !== want.addr)
				report($sformatf("result_addr %h, want %h", got_addr, want.addr));
			if (got_sts !== want.status)
				report($sformatf("status %0d, want %0d", got_sts, want.status));
		endtask
	endclass

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        s_tvalid = 1'b0;
	logic        s_tready;
	logic [31:0] s_tdata = '0;   // [15:0] req_size, [31:16] block_addr
	logic        s_tuser = 1'b0; // [0] action
	logic        m_tvalid;
	logic        m_tready = 1'b0;
	logic [15:0] m_tdata;        // [15:0] result_addr
	logic [1:0]  m_tuser;        // [1:0] status
	logic        psel = 1'b0;
	logic        penable = 1'b0;
	logic        pwrite = 1'b0;
	logic [PADDR_BITS-1:0] paddr = '0;
	logic [31:0] pwdata = '0;
	logic [31:0] prdata;
	logic        pready;

	logic        hold_req = 1'b0;
	int          hold_left = 0;
	int          stall_pct = 0;
	int          stall_span = 0;
	int          n_words = 0;

	heap_shadow heap;

	first_fit_block_allocator dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tuser  (s_tuser),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tuser  (m_tuser),
		.psel     (psel),
		.penable  (penable),
		.pwrite   (pwrite),
		.paddr    (paddr),
		.pwdata   (pwdata),
		.prdata   (prdata),
		.pready   (pready)
	);

	always begin
		#10 clk = 1'b1;
		#10 clk = 1'b0;
	end

	always @(posedge clk) begin
		if (arst_n) begin
			if (s_tvalid && s_tready)
				heap.note_request(action_t'(s_tuser), s_tdata[15:0], s_tdata[31:16]);
			if (m_tvalid && m_tready)
				heap.check_grant(m_tdata, status_t'(m_tuser));
		end
	end

	// receiver: stall rate changes after a random span, long hold on request
	always @(posedge clk) begin
		if (hold_req) begin
			hold_req <= 1'b0;
			hold_left <= HOLD_CYCLES;
			m_tready <= 1'b0;
		end else if (hold_left > 0) begin
			hold_left <= hold_left - 1;
			m_tready <= 1'b0;
		end else begin
			if (stall_span == 0) begin
				case ($urandom_range(0, 3))
					0: stall_pct <= 0;
					1: stall_pct <= 20;
					2: stall_pct <= 50;
					default: stall_pct <= 80;
				endcase
				stall_span <= $urandom_range(50, 400);
			end else begin
				stall_span <= stall_span - 1;
			end
			m_tready <= ($urandom_range(0, 99) >= stall_pct);
		end
	end

	initial begin
		#50_000_000;
		$display("tb NOT OK");
		$finish;
	end

	task automatic send(action_t act, logic [15:0] sz, logic [15:0] ad);
		s_tvalid <= 1'b1;
		s_tuser <= act;
		s_tdata <= {ad, sz};
		do @(posedge clk); while (!s_tready);
		n_words++;
	endtask

	task automatic idle(int n);
		if (n > 0) begin
			s_tvalid <= 1'b0;
			repeat (n) @(posedge clk);
		end
	endtask

	// sender stops until every owed grant has come back
	task automatic drain();
		s_tvalid <= 1'b0;
		@(posedge clk);
		while (heap.grants_due.size() != 0)
			@(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	task automatic limit_write(logic [15:0] v);
		logic [31:0] w;
		w = {16'($urandom), v};
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b1;
		paddr <= LIMIT_ADDR;
		pwdata <= w;
		@(posedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		heap.set_limit(w[ADDR_BITS-1:0]);
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
		@(posedge clk);
	endtask

	task automatic limit_read();
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b0;
		paddr <= LIMIT_ADDR;
		@(posedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		if (prdata[15:0] !== heap.limit[15:0])
			heap.report($sformatf("heap_limit reads %h, want %h", prdata[15:0],
				heap.limit[15:0]));
		psel <= 1'b0;
		penable <= 1'b0;
		@(posedge clk);
	endtask

	task automatic rand_word(int alloc_pct);
		int          r, idx;
		logic [15:0] sz, ad;
		r = $urandom_range(0, 99);
		if ($urandom_range(0, 99) < alloc_pct) begin
			if (r < 3)
				sz = 0;
			else if (r < 75)
				sz = $urandom_range(1, 64);
			else if (r < 95)
				sz = $urandom_range(65, 2048);
			else if (r < 98)
				sz = $urandom_range(2049, 65535);
			else
				sz = 16'hFFFF;
			send(ACT_ALLOC, sz, 16'($urandom));
		end else begin
			idx = (heap.count > 0) ? $urandom_range(0, heap.count - 1) : 0;
			if (heap.count > 0 && r < 30)
				ad = heap.base_tab[heap.count - 1];
			else if (heap.count > 0 && r < 80)
				ad = heap.base_tab[idx];
			else if (r < 85)
				ad = 0;
			else if (heap.count > 0 && r < 92)
				ad = heap.base_tab[idx] + (r[0] ? 16'd1 : 16'hFFFF);
			else
				ad = 16'($urandom);
			send(ACT_FREE, 16'($urandom), ad);
		end
	endtask

	task automatic run_random(int words, int alloc_pct);
		int left, burst;
		left = words;
		while (left > 0) begin
			burst = ($urandom_range(0, 3) == 0) ? $urandom_range(20, 60) : $urandom_range(1, 12);
			while (burst > 0 && left > 0) begin
				rand_word(alloc_pct);
				burst--;
				left--;
			end
			idle(($urandom_range(0, 4) == 0) ? 0 : $urandom_range(1, 15));
		end
	endtask

	initial begin
		int guard;
		heap = new();
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		limit_read();

		// corner words: null, unknown, exact fit at the top of memory, reuse, drops
		send(ACT_ALLOC, 16'd0, 16'hFFFF);
		send(ACT_FREE, 16'hFFFF, 16'd0);
		send(ACT_FREE, 16'd0, 16'hFFFF);
		send(ACT_ALLOC, 16'd65519, 16'd0);
		send(ACT_ALLOC, 16'd1, 16'd0);
		send(ACT_FREE, 16'd0, 16'd16);
		send(ACT_ALLOC, 16'hFFFF, 16'd0);
		send(ACT_ALLOC, 16'd1, 16'd0);
		send(ACT_ALLOC, 16'd100, 16'd0);
		send(ACT_ALLOC, 16'd8, 16'd0);
		send(ACT_FREE, 16'd0, 16'd33);
		send(ACT_FREE, 16'd0, 16'd33);
		send(ACT_ALLOC, 16'd50, 16'd0);
		send(ACT_ALLOC, 16'd200, 16'd0);
		send(ACT_FREE, 16'd0, 16'd149);
		send(ACT_FREE, 16'd0, 16'd173);
		send(ACT_FREE, 16'd0, 16'd149);
		send(ACT_FREE, 16'd0, 16'd149);
		send(ACT_FREE, 16'd0, 16'd34);

		// limit below the break: appends fail, reuse still works
		drain();
		limit_write(16'd100);
		limit_read();
		send(ACT_ALLOC, 16'd1, 16'd0);
		send(ACT_FREE, 16'd0, 16'd16);
		send(ACT_ALLOC, 16'd1, 16'd0);
		send(ACT_FREE, 16'd0, 16'd33);

		// no free blocks left, so every append grows the table until it is full
		drain();
		limit_write(16'hFFFF);
		repeat (MAX_BLOCKS - heap.count + 2)
			send(ACT_ALLOC, 16'($urandom_range(1, 32)), 16'($urandom));

		// long receiver hold while the sender keeps offering words
		hold_req <= 1'b1;
		repeat (10)
			rand_word(70);
		run_random(400, 70);

		drain();
		limit_write(16'd800);
		limit_read();
		run_random(300, 50);

		drain();
		limit_write(16'd0);
		run_random(120, 60);

		drain();
		limit_write(16'($urandom_range(1000, 65535)));
		limit_read();
		run_random(200, 45);
		drain();
		run_random(150, 45);

		drain();
		limit_write(16'hFFFF);
		run_random(330, 55);

		s_tvalid <= 1'b0;
		guard = 0;
		while (heap.grants_due.size() != 0 && guard < 200000) begin
			@(posedge clk);
			guard++;
		end
		repeat (150) @(posedge clk);
		if (heap.grants_due.size() != 0)
			heap.report($sformatf("%0d results never came", heap.grants_due.size()));

		$display("run: %0d words; %0d appends, %0d reuses, %0d drops from top, %0d marked free",
			n_words, heap.n_append, heap.n_reuse, heap.n_drop, heap.n_mark);
		$display("status mix ok/null/oom/unknown %0d/%0d/%0d/%0d, %0d refused on full table",
			heap.status_seen[0], heap.status_seen[1], heap.status_seen[2],
			heap.status_seen[3], heap.n_full);
		if (heap.errors == 0) begin
			$display("tb OK");
		end else begin
			$display("tb NOT OK");
		end
		$finish;
	end

endmodule
